@@ hdl/smbscrub_pkg.sv @@
// ----------------------------------------------------------------------------
// smbscrub_pkg: shared types and constants of the SMBIOS structure scrubber
// Phase encoding, register map and the per-byte result record.
// ----------------------------------------------------------------------------
package smbscrub_pkg;

    localparam int unsigned BYTE_W = 8;

    // Smallest legal formatted-header length (type byte plus length byte)
    localparam logic [BYTE_W-1:0] MIN_HEADER_LEN = 8'd2;

    // Reset values of the type registers
    localparam logic [BYTE_W-1:0] SCRUB_TYPE_FIRST_RST  = 8'd4;
    localparam logic [BYTE_W-1:0] SCRUB_TYPE_SECOND_RST = 8'hdb;

    // Register index, taken from paddr[2] (word addressing)
    localparam logic REG_SCRUB_TYPE_FIRST  = 1'b0;
    localparam logic REG_SCRUB_TYPE_SECOND = 1'b1;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_HEADER  = 2'd2,
        PH_STRINGS = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              was_scrubbed;
        logic              struct_end;
        logic              last_out;
    } result_t;

endpackage

@@ hdl/smbscrub_parser.sv @@
// ----------------------------------------------------------------------------
// smbscrub_parser: per-byte structure walker
// Holds phase, length, position and match state; computes one result per byte.
// ----------------------------------------------------------------------------
module smbscrub_parser import smbscrub_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              last_in,
    input  logic [BYTE_W-1:0] type_first,
    input  logic [BYTE_W-1:0] type_second,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic              match_reg, match_next;
    logic [BYTE_W-1:0] hlen_reg, hlen_next;
    logic [BYTE_W-1:0] hpos_reg, hpos_next;
    logic              prev_zero_reg, prev_zero_next;

    logic [BYTE_W-1:0] hpos_inc;
    logic [BYTE_W-1:0] len_fixed;
    logic              is_zero;

    assign hpos_inc  = hpos_reg + 8'd1;
    assign len_fixed = (in_byte < MIN_HEADER_LEN) ? MIN_HEADER_LEN : in_byte;
    assign is_zero   = (in_byte == '0);

    always_comb begin
        phase_next          = phase_reg;
        match_next          = match_reg;
        hlen_next           = hlen_reg;
        hpos_next           = hpos_reg;
        prev_zero_next      = prev_zero_reg;
        result.out_byte     = in_byte;
        result.was_scrubbed = 1'b0;
        result.struct_end   = 1'b0;
        result.last_out     = last_in;

        unique case (phase_reg)
            PH_TYPE: begin
                match_next = (in_byte == type_first) || (in_byte == type_second);
                phase_next = PH_LENGTH;
            end
            PH_LENGTH: begin
                hlen_next      = len_fixed;
                hpos_next      = MIN_HEADER_LEN;
                prev_zero_next = 1'b0;
                phase_next     = (MIN_HEADER_LEN >= len_fixed) ? PH_STRINGS : PH_HEADER;
            end
            PH_HEADER: begin
                if (match_reg) begin
                    result.out_byte     = '0;
                    result.was_scrubbed = 1'b1;
                end
                hpos_next = hpos_inc;
                if (hpos_inc >= hlen_reg) begin
                    prev_zero_next = 1'b0;
                    phase_next     = PH_STRINGS;
                end
            end
            PH_STRINGS: begin
                if (is_zero && prev_zero_reg) begin
                    result.struct_end = 1'b1;
                    phase_next        = PH_TYPE;
                    match_next        = 1'b0;
                    hlen_next         = '0;
                    hpos_next         = '0;
                    prev_zero_next    = 1'b0;
                end else begin
                    prev_zero_next = is_zero;
                end
            end
            default: begin
                phase_next = PH_TYPE;
            end
        endcase

        // end of buffer drops any structure in flight
        if (last_in) begin
            phase_next     = PH_TYPE;
            match_next     = 1'b0;
            hlen_next      = '0;
            hpos_next      = '0;
            prev_zero_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TYPE;
            match_reg     <= 1'b0;
            hlen_reg      <= '0;
            hpos_reg      <= '0;
            prev_zero_reg <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            match_reg     <= match_next;
            hlen_reg      <= hlen_next;
            hpos_reg      <= hpos_next;
            prev_zero_reg <= prev_zero_next;
        end
    end

endmodule

@@ hdl/smbscrub_regs.sv @@
// ----------------------------------------------------------------------------
// smbscrub_regs: APB register file
// Holds the two structure types whose header body is zeroed.
// ----------------------------------------------------------------------------
module smbscrub_regs import smbscrub_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [BYTE_W-1:0] type_first,
    output logic [BYTE_W-1:0] type_second
);

    logic [BYTE_W-1:0] type_first_reg;
    logic [BYTE_W-1:0] type_second_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_first_reg  <= SCRUB_TYPE_FIRST_RST;
            type_second_reg <= SCRUB_TYPE_SECOND_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SCRUB_TYPE_FIRST:  type_first_reg  <= pwdata[BYTE_W-1:0];
                REG_SCRUB_TYPE_SECOND: type_second_reg <= pwdata[BYTE_W-1:0];
                default:               type_first_reg  <= type_first_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SCRUB_TYPE_FIRST:  prdata = {24'd0, type_first_reg};
            REG_SCRUB_TYPE_SECOND: prdata = {24'd0, type_second_reg};
            default:               prdata = '0;
        endcase
    end

    assign type_first  = type_first_reg;
    assign type_second = type_second_reg;

endmodule

@@ hdl/smbios_structure_scrubber.sv @@
// ----------------------------------------------------------------------------
// smbios_structure_scrubber: SMBIOS structure table scrubber, top level
// A byte accepted on s_ passes through the input register into the result
// register, from which it is offered on m_.
// Throughput: one byte per cycle, sustained under continuous m_tready.
// The input register and the result register each take a new transfer
// whenever the stage behind them moves, so one byte may wait on m_ while the
// next is accepted. Reset (aresetn low, synchronous) empties both stages,
// returns the walker to awaiting a type byte and restores types 4 and 0xdb.
// ----------------------------------------------------------------------------
module smbios_structure_scrubber import smbscrub_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_in

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [0] was_scrubbed, [1] struct_end
    output logic        m_tlast    // last_out
);

    logic [BYTE_W-1:0] type_first;
    logic [BYTE_W-1:0] type_second;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // result register
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           result;

    logic              advance;   // result register can take a new byte
    logic              step;      // a byte moves from input to result register
    logic              s_xfer;

    smbscrub_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .type_first  (type_first),
        .type_second (type_second)
    );

    smbscrub_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .in_byte     (in_byte_reg),
        .last_in     (in_last_reg),
        .type_first  (type_first),
        .type_second (type_second),
        .result      (result)
    );

    // Advance the result register when it is empty or being drained;
    // take a new input transfer when the input register empties this cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = advance && in_valid_reg;
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload: hold unless a transfer lands
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.struct_end, out_reg.was_scrubbed};
    assign m_tlast  = out_reg.last_out;

`ifndef SYNTHESIS
    // a scrubbed byte always goes out as zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("scrubbed byte is not zero");

    // a terminator is the second zero of the string set, never a header byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == 8'd0 && !m_tuser[0])
        else $error("structure end on a non-terminator byte");

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a byte waiting in the input register is not lost while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_tvalid && !m_tready |=> in_valid_reg && m_tvalid)
        else $error("stalled byte dropped");
`endif

endmodule
